/* sv/cpd_pkg.sv */
// Shared constants and types for the closest pair distance unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cpd_pkg;

  // Store depth and coordinate width
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned COORD_BITS = 16;

  // Derived widths
  localparam int unsigned ADDR_W    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int unsigned ENTRY_W   = 2 * COORD_BITS;
  localparam int unsigned SQR_W     = 2 * COORD_BITS;
  localparam int unsigned SQ_W      = 2 * COORD_BITS + 1;
  localparam int unsigned BEST_W    = 2 * COORD_BITS + 2;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned Q8_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned RAD_W     = 2 * Q8_W;
  localparam int unsigned REM_W     = Q8_W + 1;
  localparam int unsigned SQRT_STEPS = Q8_W;
  localparam int unsigned STEP_W    = $clog2(SQRT_STEPS + 1);

  // Control from the sequencer to the scan engine
  typedef struct packed {
    logic              start;
    logic              clear;
    logic [ADDR_W-1:0] len;
  } scan_ctrl_t;

  // Status from the scan engine
  typedef struct packed {
    logic busy;
  } scan_stat_t;

endpackage : cpd_pkg

`default_nettype wire

/* sv/cpd_if.sv */
// Valid/ready channel interfaces for point words in and result words out.
// Depends on cpd_pkg for the field widths.
`default_nettype none

interface cpd_in_if;
  import cpd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic                          last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface : cpd_in_if

interface cpd_out_if;
  import cpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SQ_W-1:0]  min_dist_sq;
  logic [Q8_W-1:0]  min_dist_q8;
  logic             too_few_points;
  logic             overflow;

  modport source (output valid, output min_dist_sq, output min_dist_q8,
                  output too_few_points, output overflow, input ready);
  modport sink   (input valid, input min_dist_sq, input min_dist_q8,
                  input too_few_points, input overflow, output ready);
endinterface : cpd_out_if

`default_nettype wire

/* sv/cpd_scan.sv */
// Point store and pair scan engine: one stored point read per cycle,
// distance pipeline and running minimum. Depends on cpd_pkg.
`default_nettype none

module cpd_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cpd_pkg::scan_ctrl_t           ctrl_i,
  input  wire logic                          wr_en_i,
  input  wire logic [cpd_pkg::ADDR_W-1:0]    wr_addr_i,
  input  wire logic signed [cpd_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [cpd_pkg::COORD_BITS-1:0] point_y_i,
  output cpd_pkg::scan_stat_t                stat_o,
  output logic [cpd_pkg::BEST_W-1:0]         best_o
);
  import cpd_pkg::*;

  localparam int unsigned C = COORD_BITS;

  // Point store, {x, y} per entry
  logic [ENTRY_W-1:0] mem_q [MAX_POINTS];
  logic [ENTRY_W-1:0] rdata_q;

  logic signed [C-1:0] ref_x_q, ref_y_q;
  logic [ADDR_W-1:0]   rd_idx_q;
  logic [ADDR_W-1:0]   left_q;
  logic                v1_q, v2_q, v3_q;
  logic [C-1:0]        dx_q, dy_q;
  logic [SQR_W-1:0]    sqx_q, sqy_q;
  logic [BEST_W-1:0]   best_q;

  logic                issue;
  logic signed [C-1:0] sx, sy;
  logic signed [C:0]   diff_x, diff_y;
  logic [C-1:0]        dx_d, dy_d;
  logic [SQR_W-1:0]    sqx_d, sqy_d;
  logic [SQ_W-1:0]     sum;

  assign issue = (left_q != '0);

  // Write the incoming word, read one stored entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {point_x_i, point_y_i};
    end
    if (issue) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // Absolute coordinate differences
  always_comb begin
    sx     = rdata_q[ENTRY_W-1:C];
    sy     = rdata_q[C-1:0];
    diff_x = {ref_x_q[C-1], ref_x_q} - {sx[C-1], sx};
    diff_y = {ref_y_q[C-1], ref_y_q} - {sy[C-1], sy};
    dx_d   = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
    dy_d   = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
    sqx_d  = {{C{1'b0}}, dx_q} * {{C{1'b0}}, dx_q};
    sqy_d  = {{C{1'b0}}, dy_q} * {{C{1'b0}}, dy_q};
    sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  // Latch the reference point at start
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ref_x_q <= point_x_i;
      ref_y_q <= point_y_i;
    end
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
  end

  // Address sequencing, stage valids and running minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      left_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      best_q   <= '1;
    end else begin
      if (ctrl_i.start) begin
        rd_idx_q <= '0;
        left_q   <= ctrl_i.len;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
        left_q   <= left_q - 1'b1;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (ctrl_i.clear) begin
        best_q <= '1;
      end else if (v3_q && ({1'b0, sum} < best_q)) begin
        best_q <= {1'b0, sum};
      end
    end
  end

  assign stat_o.busy = issue | v1_q | v2_q | v3_q;
  assign best_o      = best_q;

  // Checks
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !(issue || v1_q || v2_q || v3_q))
    else $error("scan started while previous scan in flight");
  a_best_never_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clear && !$past(ctrl_i.clear) |=> best_q <= $past(best_q))
    else $error("running minimum increased without clear");
  a_write_not_scanned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> ctrl_i.start && (wr_addr_i == ctrl_i.len))
    else $error("store written outside the scanned range boundary");

endmodule : cpd_scan

`default_nettype wire

/* sv/cpd_sqrt.sv */
// Restoring square root, one result bit per cycle, 8 fraction bits.
// Depends on cpd_pkg.
`default_nettype none

module cpd_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cpd_pkg::SQ_W-1:0]   value_i,
  output logic                            busy_o,
  output logic [cpd_pkg::Q8_W-1:0]        root_o
);
  import cpd_pkg::*;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [Q8_W-1:0]   root_q;
  logic [STEP_W-1:0] step_q;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  // One digit pair per step
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RAD_W-SQ_W-2*FRAC_BITS){1'b0}}, value_i, {(2*FRAC_BITS){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_q != '0) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[Q8_W-2:0], fits};
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(SQRT_STEPS);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  assign busy_o = (step_q != '0);
  assign root_o = root_q;

  // Checks
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> step_q == '0)
    else $error("square root restarted while busy");
  a_root_stable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == '0 && !start_i |=> $stable(root_q))
    else $error("root changed while idle");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> {1'b0, rem_q} <= {root_q, 1'b0})
    else $error("square root remainder out of range");

endmodule : cpd_sqrt

`default_nettype wire

/* sv/closest_pair_distance_unit.sv */
// Top level of the closest pair distance unit: sequencer, set bookkeeping
// and result register. Depends on cpd_pkg, cpd_if, cpd_scan and cpd_sqrt.
//
// Usage: points arrive one word per handshake on in_i (x, y, last_point).
// Each point is written to the point store and compared against every point
// already stored in the set, one stored point per cycle through a four-stage
// read/difference/square/compare pipeline on the single read port. No new
// point is taken until that scan is through. The word marked last closes
// the set: if two or more points were stored, a restoring square root
// follows, then one result word is loaded into the output register on
// out_o. Points beyond 1024 are dropped and flagged as overflow; fewer than
// two points give too_few_points with zero distances.
// The output register parts the two sides: new points are taken while a
// result waits; a further result waits until the receiver takes the previous
// one. Reset empties the set and the output register; the store needs no
// clearing.
`default_nettype none

module closest_pair_distance_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpd_in_if.sink    in_i,
  cpd_out_if.source out_o
);
  import cpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SQRT,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic              dropped_q;
  logic              last_q;

  logic              out_valid_q;
  logic [SQ_W-1:0]   min_dist_sq_q;
  logic [Q8_W-1:0]   min_dist_q8_q;
  logic              too_few_q;
  logic              overflow_q;

  logic              accept;
  logic              room;
  logic              too_few;
  logic              out_free;
  logic              sqrt_start;
  logic              sqrt_busy;
  logic [Q8_W-1:0]   root;
  logic [BEST_W-1:0] best;
  scan_ctrl_t        scan_ctrl;
  scan_stat_t        scan_stat;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign room       = (count_q < CNT_W'(MAX_POINTS));
  assign too_few    = (count_q < CNT_W'(2));
  assign out_free   = !out_valid_q || out_o.ready;

  // Scan control: start on every accepted word, scan only the stored points
  always_comb begin
    scan_ctrl.start = accept;
    scan_ctrl.len   = room ? count_q[ADDR_W-1:0] : '0;
    scan_ctrl.clear = (state_q == S_DONE) && out_free;
    sqrt_start      = (state_q == S_SCAN) && !scan_stat.busy && last_q && !too_few;
  end

  cpd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .wr_en_i   (accept && room),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .point_x_i (in_i.point_x),
    .point_y_i (in_i.point_y),
    .stat_o    (scan_stat),
    .best_o    (best)
  );

  cpd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best[SQ_W-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // Sequencer and set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= in_i.last_point;
            if (room) begin
              count_q <= count_q + 1'b1;
            end else begin
              dropped_q <= 1'b1;
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_stat.busy) begin
            priority if (!last_q) begin
              state_q <= S_IDLE;
            end else if (too_few) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (!sqrt_busy) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            count_q   <= '0;
            dropped_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register: load on close, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      min_dist_sq_q <= too_few ? '0 : best[SQ_W-1:0];
      min_dist_q8_q <= too_few ? '0 : root;
      too_few_q     <= too_few;
      overflow_q    <= dropped_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.min_dist_sq    = min_dist_sq_q;
  assign out_o.min_dist_q8    = min_dist_q8_q;
  assign out_o.too_few_points = too_few_q;
  assign out_o.overflow       = overflow_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");
  a_sqrt_enough_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> count_q >= CNT_W'(2) && best[BEST_W-1] == 1'b0)
    else $error("square root started without a valid minimum");
  a_too_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && too_few_q |-> min_dist_sq_q == '0 && min_dist_q8_q == '0)
    else $error("distances not zero with too few points");
  a_accept_idle_engines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !scan_stat.busy && !sqrt_busy)
    else $error("word accepted while engines busy");

endmodule : closest_pair_distance_unit

`default_nettype wire
